// ===== hdl/point_charge_multipole_moments_macros.svh =====
// Assertion macros for the point charge multipole moments block.
// Included by the top level; the macros expect aclk and aresetn in scope.
`ifndef POINT_CHARGE_MULTIPOLE_MOMENTS_MACROS_SVH
`define POINT_CHARGE_MULTIPOLE_MOMENTS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PCMM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("multipole moments: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("multipole moments: next-cycle check failed");

`endif

// ===== hdl/pcmm_pkg.sv =====
// Shared types, constants and helper functions of the multipole moments block.
// Used by the controller, the datapath and the top level; depends on nothing.
package pcmm_pkg;

    // Fixed field and arithmetic widths.
    localparam int CHARGE_W  = 24;
    localparam int ACC_W     = 64;
    localparam int ORDER_W   = 2;
    localparam int NUM_OUT   = 10;
    localparam int OUT_W     = NUM_OUT * ACC_W;
    localparam int MA_W      = 32;   // multiplier operand A (charge or coordinate)
    localparam int MB_W      = 36;   // multiplier operand B (coordinate or term slice)
    localparam int PROD_W    = MA_W + MB_W;
    localparam int P_W       = 64;   // coordinate product r_u * r_w
    localparam int R2_W      = 66;   // sum of the three squares
    localparam int T_W       = 68;   // 3 r_u r_w - delta r^2
    localparam int LO_SPLIT  = 32;   // low slice of the term, taken unsigned
    localparam int LO_W      = CHARGE_W + LO_SPLIT + 1;
    localparam int HI_PROD_W = CHARGE_W + MB_W;
    localparam int TERM_W    = 74;   // widest value added into an accumulator
    localparam int DIP_SHIFT = 4;
    localparam int QUAD_SHIFT = 20;
    localparam int HI_SHIFT  = LO_SPLIT - QUAD_SHIFT;
    localparam int NUM_DIAG  = 3;

    // Order codes and reset value.
    localparam logic [ORDER_W-1:0] ORDER_CHARGE = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_DIPOLE = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_RESET  = 2'd2;

    // Last counts of the sequencer loops.
    localparam logic [2:0] LAST_PROD = 3'd5;
    localparam logic [2:0] LAST_DIP  = 3'd2;
    localparam logic [2:0] LAST_QUAD = 3'd5;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RR,
        MUL_QR,
        MUL_QLO,
        MUL_QHI
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIP,
        ST_QT,
        ST_QLO,
        ST_QHI,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_load;
        mul_op_t    mul_op;
        logic [2:0] idx;
        logic       r2_load;
        logic       t_load;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic out_free;
    } stat_t;

    // First and second axis of each unique quadrupole entry: xx yy zz xy xz yz.
    function automatic logic [1:0] quad_u(input logic [2:0] idx);
        logic [1:0] u;
        case (idx)
            3'd1:    u = 2'd1;
            3'd2:    u = 2'd2;
            3'd5:    u = 2'd1;
            default: u = 2'd0;
        endcase
        return u;
    endfunction

    function automatic logic [1:0] quad_w(input logic [2:0] idx);
        logic [1:0] w;
        case (idx)
            3'd1:    w = 2'd1;
            3'd3:    w = 2'd1;
            3'd2:    w = 2'd2;
            3'd4:    w = 2'd2;
            3'd5:    w = 2'd2;
            default: w = 2'd0;
        endcase
        return w;
    endfunction

    // Adds a wide value into a 64-bit accumulator, clamping to the signed range.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [TERM_W-1:0] val
    );
        logic signed [TERM_W:0]      s;
        logic [TERM_W-ACC_W+1:0]     top;
        logic signed [ACC_W-1:0]     r;
        s   = (TERM_W+1)'(acc) + (TERM_W+1)'(val);
        top = s[TERM_W:ACC_W-1];
        if ((top == '0) || (top == '1)) begin
            r = s[ACC_W-1:0];
        end else if (s[TERM_W]) begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hdl/pcmm_ctrl.sv =====
// Sequencer of the multipole moments block and holder of the max_order register.
// Depends on pcmm_pkg for the state, command and status types.
module pcmm_ctrl import pcmm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ORDER_W-1:0] cfg_data,
    input  stat_t              stat,
    output cmd_t               cmd
);

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic [ORDER_W-1:0] max_order_reg;

    // The register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_order_reg <= ORDER_RESET;
        end else if (cfg_valid) begin
            max_order_reg <= cfg_data;
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        s_tready    = 1'b0;
        cmd.in_load = 1'b0;
        cmd.mul_op  = MUL_NONE;
        cmd.idx     = cnt_reg;
        cmd.r2_load = 1'b0;
        cmd.t_load  = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    last_next   = s_tlast;
                    cnt_next    = '0;
                    if (max_order_reg == ORDER_CHARGE) begin
                        state_next = s_tlast ? ST_EMIT : ST_IDLE;
                    end else if (max_order_reg == ORDER_DIPOLE) begin
                        state_next = ST_DIP;
                    end else begin
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD: begin
                cmd.mul_op = MUL_RR;
                if (cnt_reg == LAST_PROD) begin
                    cnt_next   = '0;
                    state_next = ST_DIP;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_DIP: begin
                cmd.mul_op  = MUL_QR;
                cmd.r2_load = (cnt_reg == '0);
                if (cnt_reg == LAST_DIP) begin
                    cnt_next   = '0;
                    state_next = max_order_reg[1] ? ST_QT : ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_QT: begin
                cmd.t_load = 1'b1;
                state_next = ST_QLO;
            end
            ST_QLO: begin
                cmd.mul_op = MUL_QLO;
                state_next = ST_QHI;
            end
            ST_QHI: begin
                cmd.mul_op = MUL_QHI;
                if (cnt_reg == LAST_QUAD) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_QT;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/pcmm_datapath.sv =====
// Datapath of the multipole moments block: input latch, shared multiplier,
// saturating accumulators and the output register. Depends on pcmm_pkg.
module pcmm_datapath import pcmm_pkg::*; #(
    parameter  int COORD_WIDTH = 24,
    localparam int IN_DATA_W   = ((3 * COORD_WIDTH + CHARGE_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata
);

    logic signed [COORD_WIDTH-1:0] r_reg [3];
    logic signed [CHARGE_W-1:0]    q_reg;
    logic signed [CHARGE_W-1:0]    q_in;
    logic signed [P_W-1:0]         p_reg [6];
    logic signed [R2_W-1:0]        r2_reg;
    logic signed [T_W-1:0]         t_reg, t_next;
    logic signed [P_W-1:0]         p_sel;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [MB_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]      prod_reg;
    mul_op_t                       wb_op_reg;
    logic [2:0]                    wb_idx_reg;
    logic signed [LO_W-1:0]        lo_reg;
    logic signed [TERM_W-1:0]      term_reg;
    logic                          term_valid_reg;
    logic [2:0]                    term_idx_reg;
    logic signed [ACC_W-1:0]       charge_reg;
    logic signed [ACC_W-1:0]       dip_reg [3];
    logic signed [ACC_W-1:0]       quad_reg [6];
    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    assign q_in = s_tdata[3*COORD_WIDTH +: CHARGE_W];

    // Input latch.
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            r_reg[0] <= s_tdata[0 +: COORD_WIDTH];
            r_reg[1] <= s_tdata[COORD_WIDTH +: COORD_WIDTH];
            r_reg[2] <= s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
            q_reg    <= q_in;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = MA_W'(q_reg);
        mul_b = MB_W'(r_reg[cmd.idx[1:0]]);
        case (cmd.mul_op)
            MUL_RR: begin
                mul_a = MA_W'(r_reg[quad_u(cmd.idx)]);
                mul_b = MB_W'(r_reg[quad_w(cmd.idx)]);
            end
            MUL_QLO: begin
                mul_b = $signed({{(MB_W-LO_SPLIT){1'b0}}, t_reg[LO_SPLIT-1:0]});
            end
            MUL_QHI: begin
                mul_b = $signed(t_reg[T_W-1:LO_SPLIT]);
            end
            default: begin
            end
        endcase
    end

    // Term 3 r_u r_w, less r^2 on the diagonal.
    assign p_sel  = p_reg[cmd.idx];
    assign t_next = (T_W'(p_sel) <<< 1) + T_W'(p_sel)
                  - ((cmd.idx < 3'(NUM_DIAG)) ? T_W'(r2_reg) : T_W'(0));

    // Multiplier stage with its writeback tag.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            wb_op_reg <= MUL_NONE;
        end else begin
            wb_op_reg <= cmd.mul_op;
        end
        wb_idx_reg <= cmd.idx;
    end

    // Coordinate products, r^2, term register, low partial product, quad term.
    always_ff @(posedge aclk) begin
        if (wb_op_reg == MUL_RR) begin
            p_reg[wb_idx_reg] <= prod_reg[P_W-1:0];
        end
        if (cmd.r2_load) begin
            r2_reg <= R2_W'(p_reg[0]) + R2_W'(p_reg[1]) + R2_W'(p_reg[2]);
        end
        if (cmd.t_load) begin
            t_reg <= t_next;
        end
        if (wb_op_reg == MUL_QLO) begin
            lo_reg <= prod_reg[LO_W-1:0];
        end
        if (wb_op_reg == MUL_QHI) begin
            term_reg <= (TERM_W'($signed(prod_reg[HI_PROD_W-1:0])) <<< HI_SHIFT)
                      + TERM_W'(lo_reg >>> QUAD_SHIFT);
        end
        term_idx_reg <= wb_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_valid_reg <= 1'b0;
        end else begin
            term_valid_reg <= (wb_op_reg == MUL_QHI);
        end
    end

    // Saturating accumulators; emitting the totals clears them.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            charge_reg <= '0;
            for (int i = 0; i < 3; i++) dip_reg[i] <= '0;
            for (int i = 0; i < 6; i++) quad_reg[i] <= '0;
        end else begin
            if (cmd.in_load) begin
                charge_reg <= sat_add(charge_reg, TERM_W'(q_in));
            end
            if (wb_op_reg == MUL_QR) begin
                dip_reg[wb_idx_reg[1:0]] <= sat_add(dip_reg[wb_idx_reg[1:0]],
                                                    TERM_W'(prod_reg >>> DIP_SHIFT));
            end
            if (term_valid_reg) begin
                quad_reg[term_idx_reg] <= sat_add(quad_reg[term_idx_reg], term_reg);
            end
        end
    end

    // Output register, so a held result does not block the next item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            out_data_reg <= {quad_reg[5], quad_reg[4], quad_reg[3], quad_reg[2],
                             quad_reg[1], quad_reg[0], dip_reg[2], dip_reg[1],
                             dip_reg[0], charge_reg};
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign stat.busy     = (wb_op_reg != MUL_NONE) || term_valid_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

// ===== hdl/point_charge_multipole_moments.sv =====
// Top level of the point charge multipole moments block.
// Joins pcmm_ctrl and pcmm_datapath; uses pcmm_pkg and the assertion macros.
//
// Usage:
//   s_ channel: one point charge per item. s_tdata holds pos_x, pos_y, pos_z
//   and charge_value; s_tlast marks the final charge of a set.
//   m_ channel: one result item per set, carrying the ten totals.
//   cfg_ channel: writes max_order (0 charge, 1 adds dipole, 2 or 3 adds
//   quadrupole); write only while the block is idle.
// Throughput is set by the single shared multiplier that the sequencer steps
// through each product: one item per cycle at order 0, save after a last item.
// Otherwise an item waits for six coordinate products (order 2 or 3), three
// dipole products, two partial products per quadrupole entry and pipeline drain.
// After a last item the EMIT state moves the totals into the output register
// once it is free; m_tvalid rises the cycle after that.
// Reset clears all totals, drops any held result and sets max_order to 2.
// If the receiver stalls, the result stays in the output register while the
// next set is accumulated; the following last item waits until it is taken.
`include "point_charge_multipole_moments_macros.svh"

module point_charge_multipole_moments import pcmm_pkg::*; #(
    parameter  int COORD_WIDTH = 24,
    localparam int IN_DATA_W   = ((3 * COORD_WIDTH + CHARGE_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, lowest bits first: pos_x, pos_y, pos_z, charge_value, zero pad
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, lowest bits first: total_charge, dipole_x, dipole_y, dipole_z,
    // quad_xx, quad_yy, quad_zz, quad_xy, quad_xz, quad_yz
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ORDER_W-1:0]   cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    pcmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcmm_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A new item is taken only when no product is still in flight.
    `PCMM_ASSERT_IMPL(a_accept_quiet, s_tvalid && s_tready, !stat.busy)
    // Totals move to the output only when the output register can take them.
    `PCMM_ASSERT_IMPL(a_emit_free, cmd.emit, !m_tvalid || m_tready)
    // An emitted result is offered in the next cycle.
    `PCMM_ASSERT_NEXT(a_emit_shows, cmd.emit, m_tvalid)

endmodule
